// ===== design/qarc_pkg.sv =====
package qarc_pkg;

  localparam int QW = 16;
  localparam int AW = 24;
  localparam int RW = 20;
  localparam int TW = 24;
  localparam int GW = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int PW = 2 * QW;
  localparam int SW = PW + 2;
  localparam int GPW = GW + 1 + SW;
  localparam int APW = AW + SW;
  localparam int ASW = APW + 2;

  localparam int RATE_SHIFT = 26;
  localparam int THR_SHIFT = 28;

  localparam logic [GW-1:0] GAIN_RESET = 16'd5120;
  localparam logic signed [RW-1:0] RATE_MAX = 20'sd262144;
  localparam logic signed [RW-1:0] RATE_MIN = -20'sd262144;
  localparam logic signed [TW-1:0] THR_MAX = 24'sh7FFFFF;
  localparam logic signed [TW-1:0] THR_MIN = 24'sh800000;

  localparam logic ADDR_GAIN = 1'b0;

  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic signed [SW-1:0] ev_x;
    logic signed [SW-1:0] ev_y;
    logic signed [SW-1:0] ev_z;
    logic signed [SW-1:0] zx;
    logic signed [SW-1:0] zy;
    logic signed [SW-1:0] zz;
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] az;
  } qarc_err_t;

endpackage

// ===== design/qarc_cfg.sv =====
module qarc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qarc_pkg::ADDR_W-1:0]   paddr,
  input  logic [qarc_pkg::DATA_W-1:0]   pwdata,
  output logic [qarc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [qarc_pkg::GW-1:0]       gain
);
  import qarc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == ADDR_GAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (wr_en) begin
      gain <= pwdata[GW-1:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == ADDR_GAIN) begin
      prdata = DATA_W'(gain);
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== design/qarc_err.sv =====
module qarc_err (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [qarc_pkg::QW-1:0]       curr_w,
  input  logic signed [qarc_pkg::QW-1:0]       curr_x,
  input  logic signed [qarc_pkg::QW-1:0]       curr_y,
  input  logic signed [qarc_pkg::QW-1:0]       curr_z,
  input  logic signed [qarc_pkg::QW-1:0]       ref_w,
  input  logic signed [qarc_pkg::QW-1:0]       ref_x,
  input  logic signed [qarc_pkg::QW-1:0]       ref_y,
  input  logic signed [qarc_pkg::QW-1:0]       ref_z,
  input  logic signed [qarc_pkg::AW-1:0]       acc_x,
  input  logic signed [qarc_pkg::AW-1:0]       acc_y,
  input  logic signed [qarc_pkg::AW-1:0]       acc_z,
  output qarc_pkg::qarc_err_t                  err
);
  import qarc_pkg::*;

  logic                 s1_valid;
  logic signed [PW-1:0] ep [16];
  logic signed [PW-1:0] zp [8];
  logic signed [AW-1:0] s1_ax;
  logic signed [AW-1:0] s1_ay;
  logic signed [AW-1:0] s1_az;
  logic signed [SW-1:0] ew;
  logic signed [SW-1:0] zx_half;
  logic signed [SW-1:0] zy_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ep[0]  <= curr_w * ref_w;
    ep[1]  <= curr_x * ref_x;
    ep[2]  <= curr_y * ref_y;
    ep[3]  <= curr_z * ref_z;
    ep[4]  <= curr_w * ref_x;
    ep[5]  <= curr_x * ref_w;
    ep[6]  <= curr_y * ref_z;
    ep[7]  <= curr_z * ref_y;
    ep[8]  <= curr_w * ref_y;
    ep[9]  <= curr_x * ref_z;
    ep[10] <= curr_y * ref_w;
    ep[11] <= curr_z * ref_x;
    ep[12] <= curr_w * ref_z;
    ep[13] <= curr_x * ref_y;
    ep[14] <= curr_y * ref_x;
    ep[15] <= curr_z * ref_w;
    zp[0]  <= curr_w * curr_y;
    zp[1]  <= curr_x * curr_z;
    zp[2]  <= curr_y * curr_z;
    zp[3]  <= curr_w * curr_x;
    zp[4]  <= curr_w * curr_w;
    zp[5]  <= curr_x * curr_x;
    zp[6]  <= curr_y * curr_y;
    zp[7]  <= curr_z * curr_z;
    s1_ax  <= acc_x;
    s1_ay  <= acc_y;
    s1_az  <= acc_z;
  end

  assign ew = SW'(ep[0]) + SW'(ep[1]) + SW'(ep[2]) + SW'(ep[3]);
  assign zx_half = SW'(zp[0]) + SW'(zp[1]);
  assign zy_half = SW'(zp[2]) - SW'(zp[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      err.valid <= 1'b0;
    end else begin
      err.valid <= s1_valid;
    end
    err.neg  <= ew[SW-1];
    err.ev_x <= SW'(ep[4]) - SW'(ep[5]) - SW'(ep[6]) + SW'(ep[7]);
    err.ev_y <= SW'(ep[8]) + SW'(ep[9]) - SW'(ep[10]) - SW'(ep[11]);
    err.ev_z <= SW'(ep[12]) - SW'(ep[13]) + SW'(ep[14]) - SW'(ep[15]);
    err.zx   <= zx_half <<< 1;
    err.zy   <= zy_half <<< 1;
    err.zz   <= SW'(zp[4]) - SW'(zp[5]) - SW'(zp[6]) + SW'(zp[7]);
    err.ax   <= s1_ax;
    err.ay   <= s1_ay;
    err.az   <= s1_az;
  end

endmodule

// ===== design/qarc_out.sv =====
module qarc_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qarc_pkg::qarc_err_t                  err,
  input  logic [qarc_pkg::GW-1:0]              gain,
  output logic                                 done,
  output logic signed [qarc_pkg::RW-1:0]       rate_x,
  output logic signed [qarc_pkg::RW-1:0]       rate_y,
  output logic signed [qarc_pkg::RW-1:0]       rate_z,
  output logic signed [qarc_pkg::TW-1:0]       thrust_z
);
  import qarc_pkg::*;

  localparam logic signed [GPW:0] RATE_HALF = (GPW + 1)'(2 ** (RATE_SHIFT - 1));
  localparam logic signed [ASW-1:0] THR_HALF = ASW'(2 ** (THR_SHIFT - 1));

  logic                  s3_valid;
  logic                  s3_neg;
  logic signed [GW:0]    gain_s;
  logic signed [GPW-1:0] gp_x;
  logic signed [GPW-1:0] gp_y;
  logic signed [GPW-1:0] gp_z;
  logic signed [APW-1:0] ap_x;
  logic signed [APW-1:0] ap_y;
  logic signed [APW-1:0] ap_z;
  logic signed [ASW-1:0] thr_sum;
  logic signed [ASW-1:0] thr_shr;
  logic signed [TW-1:0]  thr_sat;

  function automatic logic signed [RW-1:0] rate_sat(input logic signed [GPW-1:0] p,
                                                    input logic neg);
    logic signed [GPW:0] v;
    logic signed [GPW:0] t;
    v = neg ? -((GPW + 1)'(p)) : (GPW + 1)'(p);
    t = (v + RATE_HALF) >>> RATE_SHIFT;
    if (t > (GPW + 1)'(RATE_MAX)) begin
      rate_sat = RATE_MAX;
    end else if (t < (GPW + 1)'(RATE_MIN)) begin
      rate_sat = RATE_MIN;
    end else begin
      rate_sat = t[RW-1:0];
    end
  endfunction

  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= err.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_neg <= err.neg;
    gp_x   <= gain_s * err.ev_x;
    gp_y   <= gain_s * err.ev_y;
    gp_z   <= gain_s * err.ev_z;
    ap_x   <= err.ax * err.zx;
    ap_y   <= err.ay * err.zy;
    ap_z   <= err.az * err.zz;
  end

  assign thr_sum = ASW'(ap_x) + ASW'(ap_y) + ASW'(ap_z) + THR_HALF;
  assign thr_shr = thr_sum >>> THR_SHIFT;

  always_comb begin
    if (thr_shr > ASW'(THR_MAX)) begin
      thr_sat = THR_MAX;
    end else if (thr_shr < ASW'(THR_MIN)) begin
      thr_sat = THR_MIN;
    end else begin
      thr_sat = thr_shr[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    rate_x   <= rate_sat(gp_x, s3_neg);
    rate_y   <= rate_sat(gp_y, s3_neg);
    rate_z   <= rate_sat(gp_z, s3_neg);
    thrust_z <= thr_sat;
  end

endmodule

// ===== design/quaternion_attitude_rate_command.sv =====
// Quaternion-error attitude controller.
// Input: drive the current and reference quaternions (Q1.14, w first) and the
// reference acceleration, and raise start; a transaction is taken at each rising
// edge with start high and busy low. busy is high only during reset, so a new
// transaction may enter every cycle.
// Output: done pulses for one cycle with rate_x/y/z and thrust_z valid in that
// cycle. Each transaction passes through four register stages: products, sums,
// gain/acceleration multiplies, round and saturate; done is registered with the
// outputs in the last stage. One result per transaction, in order. Throughput is
// one per cycle while busy is low.
// The receiver has no way to stall the output; results must be taken when done.
// Configuration: APB port, rate_gain (Q8.8, 2/tau) at address 0, written with
// psel/penable/pwrite high; pready is always high. Write it only while the
// pipeline is empty.
// Reset (rst, synchronous) empties the pipeline and loads rate_gain with 20.0.
module quaternion_attitude_rate_command (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qarc_pkg::QW-1:0]       curr_w,
  input  logic signed [qarc_pkg::QW-1:0]       curr_x,
  input  logic signed [qarc_pkg::QW-1:0]       curr_y,
  input  logic signed [qarc_pkg::QW-1:0]       curr_z,
  input  logic signed [qarc_pkg::QW-1:0]       ref_w,
  input  logic signed [qarc_pkg::QW-1:0]       ref_x,
  input  logic signed [qarc_pkg::QW-1:0]       ref_y,
  input  logic signed [qarc_pkg::QW-1:0]       ref_z,
  input  logic signed [qarc_pkg::AW-1:0]       acc_x,
  input  logic signed [qarc_pkg::AW-1:0]       acc_y,
  input  logic signed [qarc_pkg::AW-1:0]       acc_z,
  output logic                                 done,
  output logic signed [qarc_pkg::RW-1:0]       rate_x,
  output logic signed [qarc_pkg::RW-1:0]       rate_y,
  output logic signed [qarc_pkg::RW-1:0]       rate_z,
  output logic signed [qarc_pkg::TW-1:0]       thrust_z,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qarc_pkg::ADDR_W-1:0]          paddr,
  input  logic [qarc_pkg::DATA_W-1:0]          pwdata,
  output logic [qarc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import qarc_pkg::*;

  logic            accept;
  logic [GW-1:0]   gain;
  qarc_err_t       err;

  assign busy = rst;
  assign accept = start && !busy;

  qarc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain    (gain)
  );

  qarc_err u_err (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .curr_w   (curr_w),
    .curr_x   (curr_x),
    .curr_y   (curr_y),
    .curr_z   (curr_z),
    .ref_w    (ref_w),
    .ref_x    (ref_x),
    .ref_y    (ref_y),
    .ref_z    (ref_z),
    .acc_x    (acc_x),
    .acc_y    (acc_y),
    .acc_z    (acc_z),
    .err      (err)
  );

  qarc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .err      (err),
    .gain     (gain),
    .done     (done),
    .rate_x   (rate_x),
    .rate_y   (rate_y),
    .rate_z   (rate_z),
    .thrust_z (thrust_z)
  );

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("done without a matching transaction");

  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    ($past(accept, 4) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)) |-> done)
    else $error("transaction lost in pipeline");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rate_x <= RATE_MAX && rate_x >= RATE_MIN && rate_y <= RATE_MAX &&
              rate_y >= RATE_MIN && rate_z <= RATE_MAX && rate_z >= RATE_MIN))
    else $error("rate command outside saturation range");

  a_gain_reset: assert property (@(posedge clk) $past(rst) |-> gain == GAIN_RESET)
    else $error("gain not restored by reset");
`endif

endmodule

// ===== tb/quaternion_attitude_rate_command_checker.sv =====
module quaternion_attitude_rate_command_checker
  import qarc_pkg::*;
#(
  parameter logic [ADDR_W-1:0] GAIN_ADDR = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [QW-1:0]     curr_w,
  input  logic signed [QW-1:0]     curr_x,
  input  logic signed [QW-1:0]     curr_y,
  input  logic signed [QW-1:0]     curr_z,
  input  logic signed [QW-1:0]     ref_w,
  input  logic signed [QW-1:0]     ref_x,
  input  logic signed [QW-1:0]     ref_y,
  input  logic signed [QW-1:0]     ref_z,
  input  logic signed [AW-1:0]     acc_x,
  input  logic signed [AW-1:0]     acc_y,
  input  logic signed [AW-1:0]     acc_z,
  input  logic                     done,
  input  logic signed [RW-1:0]     rate_x,
  input  logic signed [RW-1:0]     rate_y,
  input  logic signed [RW-1:0]     rate_z,
  input  logic signed [TW-1:0]     thrust_z,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  input  logic [DATA_W-1:0]        prdata,
  input  logic                     pready,
  output int                       mismatches,
  output int                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RW-1:0] rate_x;
    logic signed [RW-1:0] rate_y;
    logic signed [RW-1:0] rate_z;
    logic signed [TW-1:0] thrust_z;
  } rate_cmd_t;

  rate_cmd_t     rate_cmd_q[$];
  logic [GW-1:0] gain = GAIN_RESET;
  int            err_count = 0;

  function automatic rate_cmd_t predict_command(
    input logic [GW-1:0]         g,
    input logic signed [QW-1:0]  cw, cx, cy, cz, tw, tx, ty, tz,
    input logic signed [AW-1:0]  ax, ay, az
  );
    longint    qw, qx, qy, qz, pw, px, py, pz, fx, fy, fz;
    longint    ew, zx, zy, zz, p, t;
    longint    ev[3];
    longint    rnd[3];
    rate_cmd_t res;
    qw = cw; qx = cx; qy = cy; qz = cz;
    pw = tw; px = tx; py = ty; pz = tz;
    fx = ax; fy = ay; fz = az;
    ew    = qw * pw + qx * px + qy * py + qz * pz;
    ev[0] = qw * px - qx * pw - qy * pz + qz * py;
    ev[1] = qw * py + qx * pz - qy * pw - qz * px;
    ev[2] = qw * pz - qx * py + qy * px - qz * pw;
    for (int i = 0; i < 3; i++) begin
      p = longint'(g) * ((ew >= 0) ? ev[i] : -ev[i]);
      rnd[i] = (p + (longint'(1) <<< (RATE_SHIFT - 1))) >>> RATE_SHIFT;
      if (rnd[i] > RATE_MAX) rnd[i] = RATE_MAX;
      if (rnd[i] < RATE_MIN) rnd[i] = RATE_MIN;
    end
    zx = 2 * (qw * qy + qx * qz);
    zy = 2 * (qy * qz - qw * qx);
    zz = qw * qw - qx * qx - qy * qy + qz * qz;
    t = (fx * zx + fy * zy + fz * zz + (longint'(1) <<< (THR_SHIFT - 1))) >>> THR_SHIFT;
    if (t > THR_MAX) t = THR_MAX;
    if (t < THR_MIN) t = THR_MIN;
    res.rate_x   = RW'(rnd[0]);
    res.rate_y   = RW'(rnd[1]);
    res.rate_z   = RW'(rnd[2]);
    res.thrust_z = TW'(t);
    return res;
  endfunction

  function automatic void check_field(input string name, input longint exp_val,
                                      input longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    rate_cmd_t exp_cmd;
    if (rst) begin
      rate_cmd_q.delete();
      gain = GAIN_RESET;
    end else begin
      if (psel && penable && pready && !pwrite && paddr == GAIN_ADDR)
        check_field("rate_gain", gain, prdata[GW-1:0]);
      if (psel && penable && pready && pwrite && paddr == GAIN_ADDR)
        gain = pwdata[GW-1:0];
      if (start && !busy)
        rate_cmd_q.push_back(predict_command(gain, curr_w, curr_x, curr_y, curr_z,
                                             ref_w, ref_x, ref_y, ref_z,
                                             acc_x, acc_y, acc_z));
      if (done) begin
        if (rate_cmd_q.size() == 0) begin
          $error("result transaction with no command pending");
          err_count++;
        end else begin
          exp_cmd = rate_cmd_q.pop_front();
          check_field("rate_x", exp_cmd.rate_x, rate_x);
          check_field("rate_y", exp_cmd.rate_y, rate_y);
          check_field("rate_z", exp_cmd.rate_z, rate_z);
          check_field("thrust_z", exp_cmd.thrust_z, thrust_z);
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= rate_cmd_q.size();
  end

endmodule

// ===== tb/quaternion_attitude_rate_command_test.sv =====
module quaternion_attitude_rate_command_test
  import qarc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] GAIN_ADDR = ADDR_W'(4 * ADDR_GAIN);
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_PAD = 8;
  localparam int PHASE_ITEMS = 175;

  typedef enum {COMP_NOMINAL, COMP_RAW, COMP_SMALL, COMP_EDGE} comp_mode_e;
  typedef enum {TGT_FREE, TGT_NEAR, TGT_OPPOSITE, TGT_ORTHOGONAL} tgt_shape_e;

  typedef struct packed {
    logic signed [QW-1:0] cw, cx, cy, cz;
    logic signed [QW-1:0] tw, tx, ty, tz;
    logic signed [AW-1:0] ax, ay, az;
  } att_cmd_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [QW-1:0] curr_w = '0, curr_x = '0, curr_y = '0, curr_z = '0;
  logic signed [QW-1:0] ref_w = '0, ref_x = '0, ref_y = '0, ref_z = '0;
  logic signed [AW-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic                 done;
  logic signed [RW-1:0] rate_x, rate_y, rate_z;
  logic signed [TW-1:0] thrust_z;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  int                   mismatches;
  int                   outstanding;
  int                   stall_cycles = 0;

  quaternion_attitude_rate_command i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .curr_w   (curr_w),
    .curr_x   (curr_x),
    .curr_y   (curr_y),
    .curr_z   (curr_z),
    .ref_w    (ref_w),
    .ref_x    (ref_x),
    .ref_y    (ref_y),
    .ref_z    (ref_z),
    .acc_x    (acc_x),
    .acc_y    (acc_y),
    .acc_z    (acc_z),
    .done     (done),
    .rate_x   (rate_x),
    .rate_y   (rate_y),
    .rate_z   (rate_z),
    .thrust_z (thrust_z),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  quaternion_attitude_rate_command_checker #(
    .GAIN_ADDR (GAIN_ADDR)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .curr_w      (curr_w),
    .curr_x      (curr_x),
    .curr_y      (curr_y),
    .curr_z      (curr_z),
    .ref_w       (ref_w),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .ref_z       (ref_z),
    .acc_x       (acc_x),
    .acc_y       (acc_y),
    .acc_z       (acc_z),
    .done        (done),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .rate_z      (rate_z),
    .thrust_z    (thrust_z),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic att_cmd_t make_cmd(
    input int cw, cx, cy, cz, tw, tx, ty, tz,
    input int ax, ay, az
  );
    att_cmd_t c;
    c.cw = QW'(cw); c.cx = QW'(cx); c.cy = QW'(cy); c.cz = QW'(cz);
    c.tw = QW'(tw); c.tx = QW'(tx); c.ty = QW'(ty); c.tz = QW'(tz);
    c.ax = AW'(ax); c.ay = AW'(ay); c.az = AW'(az);
    return c;
  endfunction

  function automatic comp_mode_e pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return COMP_NOMINAL;
    if (r < 7) return COMP_RAW;
    if (r < 8) return COMP_SMALL;
    return COMP_EDGE;
  endfunction

  function automatic logic signed [QW-1:0] pick_comp(input comp_mode_e mode);
    int t;
    case (mode)
      COMP_NOMINAL: t = int'($urandom_range(0, 32768)) - 16384;
      COMP_RAW:     t = int'($urandom);
      COMP_SMALL:   t = int'($urandom_range(0, 128)) - 64;
      default: begin
        case ($urandom_range(0, 4))
          0:       t = 0;
          1:       t = 16384;
          2:       t = -16384;
          3:       t = 32767;
          default: t = -32768;
        endcase
      end
    endcase
    return QW'(t);
  endfunction

  function automatic logic signed [AW-1:0] pick_accel(input comp_mode_e mode);
    int t;
    case (mode)
      COMP_NOMINAL: t = int'($urandom_range(0, 2097152)) - 1048576;
      COMP_RAW:     t = int'($urandom);
      COMP_SMALL:   t = int'($urandom_range(0, 4096)) - 2048;
      default: begin
        case ($urandom_range(0, 4))
          0:       t = 0;
          1:       t = 1;
          2:       t = -1;
          3:       t = 8388607;
          default: t = -8388608;
        endcase
      end
    endcase
    return AW'(t);
  endfunction

  function automatic att_cmd_t random_cmd();
    att_cmd_t   c;
    comp_mode_e cm;
    comp_mode_e am;
    int         r;
    tgt_shape_e shape;
    cm = pick_mode();
    am = pick_mode();
    r = $urandom_range(0, 9);
    if (r < 4) shape = TGT_FREE;
    else if (r < 6) shape = TGT_NEAR;
    else if (r < 8) shape = TGT_OPPOSITE;
    else shape = TGT_ORTHOGONAL;
    c.cw = pick_comp(cm);
    c.cx = pick_comp(cm);
    c.cy = pick_comp(cm);
    c.cz = pick_comp(cm);
    case (shape)
      TGT_NEAR: begin
        c.tw = c.cw + pick_comp(COMP_SMALL);
        c.tx = c.cx + pick_comp(COMP_SMALL);
        c.ty = c.cy + pick_comp(COMP_SMALL);
        c.tz = c.cz + pick_comp(COMP_SMALL);
      end
      TGT_OPPOSITE: begin
        c.tw = -c.cw + pick_comp(COMP_SMALL);
        c.tx = -c.cx + pick_comp(COMP_SMALL);
        c.ty = -c.cy + pick_comp(COMP_SMALL);
        c.tz = -c.cz + pick_comp(COMP_SMALL);
      end
      TGT_ORTHOGONAL: begin
        c.tw = -c.cx;
        c.tx = c.cw;
        c.ty = -c.cz;
        c.tz = c.cy;
      end
      default: begin
        c.tw = pick_comp(pick_mode());
        c.tx = pick_comp(pick_mode());
        c.ty = pick_comp(pick_mode());
        c.tz = pick_comp(pick_mode());
      end
    endcase
    c.ax = pick_accel(am);
    c.ay = pick_accel(am);
    c.az = pick_accel(am);
    return c;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_fields(input att_cmd_t c);
    curr_w <= c.cw;
    curr_x <= c.cx;
    curr_y <= c.cy;
    curr_z <= c.cz;
    ref_w  <= c.tw;
    ref_x  <= c.tx;
    ref_y  <= c.ty;
    ref_z  <= c.tz;
    acc_x  <= c.ax;
    acc_y  <= c.ay;
    acc_z  <= c.az;
  endtask

  task automatic issue(input att_cmd_t c);
    drive_fields(c);
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // scramble the fields while idle; they must be ignored
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      drive_fields(random_cmd());
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic retune(input logic [GW-1:0] g);
    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    apb_access(1'b1, GAIN_ADDR, DATA_W'(g));
    apb_access(1'b0, GAIN_ADDR, '0);
  endtask

  task automatic run_random(input int count);
    int burst_lo;
    burst_lo = $urandom_range(0, count / 2);
    for (int i = 0; i < count; i++) begin
      issue(random_cmd());
      if ($urandom_range(0, 99) == 0)
        wait_drained();
      else if (i < burst_lo || i > burst_lo + 40)
        pause_sender(idle_gap());
    end
  endtask

  initial begin
    att_cmd_t      corner_cmds[$];
    logic [GW-1:0] gains[8];

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, GAIN_ADDR, '0);

    corner_cmds.push_back(make_cmd(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
    corner_cmds.push_back(make_cmd(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                                   8388607, 8388607, 8388607));
    corner_cmds.push_back(make_cmd(-16384, -16384, -16384, -16384,
                                   -16384, -16384, -16384, -16384,
                                   -8388608, -8388608, -8388608));
    corner_cmds.push_back(make_cmd(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                                   8388607, -8388608, 8388607));
    corner_cmds.push_back(make_cmd(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 1024));
    corner_cmds.push_back(make_cmd(0, 16384, 0, 0, 0, 0, 16384, 0, 1024, -1024, 0));
    corner_cmds.push_back(make_cmd(16384, 0, 0, 0, -16384, 100, -200, 300, 0, 0, -1));
    corner_cmds.push_back(make_cmd(16384, 0, 0, 0, 16380, 50, -50, 25, 1, -1, 1));
    corner_cmds.push_back(make_cmd(-32768, -32768, -32768, -32768,
                                   32767, -32768, -32768, 32767, 0, 0, 0));
    corner_cmds.push_back(make_cmd(-32768, -32768, -32768, -32768,
                                   32767, 32767, 32767, -32768, 0, 0, 0));
    corner_cmds.push_back(make_cmd(32767, 0, 0, 32767, 16384, 0, 0, 0, 0, 0, 8388607));
    corner_cmds.push_back(make_cmd(32767, 0, 0, 32767, 16384, 0, 0, 0, 0, 0, -8388608));
    corner_cmds.push_back(make_cmd(1, -1, 1, -1, -1, 1, -1, 1, -1, -1, -1));
    corner_cmds.push_back(make_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    corner_cmds.push_back(make_cmd(8192, 0, 0, 8192, 16384, 0, 0, 0, 0, 0, 1));
    corner_cmds.push_back(make_cmd(8192, 0, 0, 8192, 16384, 0, 0, 0, 0, 0, -1));
    corner_cmds.push_back(make_cmd(16384, 0, 0, 0, 16384, 10, -10, 0, 0, 0, 0));
    corner_cmds.push_back(make_cmd(16384, 16384, 16384, 0, 16384, 0, 0, 0,
                                   8388607, -8388608, 0));
    foreach (corner_cmds[i]) begin
      issue(corner_cmds[i]);
      pause_sender($urandom_range(0, 2));
    end

    gains = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0100, GW'($urandom_range(1, 65534)),
              GW'($urandom), GAIN_RESET, 16'h8000};
    foreach (gains[p]) begin
      retune(gains[p]);
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
